// ----- src/assert_macros.svh -----
// Assertion macros used by the RTL of the key/value command-line parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- src/clkvp_pkg.sv -----
// Package with types, codes and constants of the key/value command-line parser.
package clkvp_pkg;

  localparam int MAX_PARAMS       = 8;
  localparam int KEY_LIMIT        = 16;
  localparam int VALUE_LIMIT      = 32;
  localparam int NAME_STORE_DEPTH = 32;
  localparam int NAME_EMIT_CAP    = 32;
  localparam int NAME_ADDR_W      = (NAME_STORE_DEPTH > 1) ? $clog2(NAME_STORE_DEPTH) : 1;
  localparam int NAME_CNT_W       = $clog2(NAME_STORE_DEPTH + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_KEY,
    KIND_VALUE,
    KIND_NAME,
    KIND_END,
    KIND_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    ERR_RAW_FULL,
    ERR_NAME_FULL,
    ERR_KEY_LONG,
    ERR_VALUE_LONG,
    ERR_TIMEOUT
  } err_t;

  typedef enum logic [2:0] {
    REG_TERMINATOR,
    REG_FIELD_SEP,
    REG_PAIR_SEP,
    REG_TIMEOUT,
    REG_NAME_LIMIT,
    REG_MESSAGE_LIMIT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEND,
    ST_TRIM_RD,
    ST_TRIM_CHK,
    ST_NAME_RD,
    ST_NAME_PUT,
    ST_END
  } state_t;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_in;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] param_index;
    logic [5:0] position;
    logic [7:0] char_out;
    logic [3:0] param_total;
    logic [2:0] error_code;
    logic       timed_out;
    logic       last;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

// ----- src/clkvp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module clkvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/command_line_key_value_parser.sv -----
// Top level of the key/value command-line parser with its sequencer and name store.
//
// Each input transfer is a received byte or a millisecond tick, registered
// when taken and executed in the next cycle; a key, value or error result
// then passes a send state that moves it into the output register. A
// terminator walks the name store, a RAM with registered read: a read and a
// check state for each trailing whitespace character trimmed and for the last
// name character checked, if any is left, a read and a put state for each
// name character sent, then an end state for the end item, each send also
// waiting while the result side stalls. The input side stalls while an item
// is being worked on, and configuration writes are taken only while it does not.
`include "assert_macros.svh"

module command_line_key_value_parser
  import clkvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  state_t state, state_next;
  item_t  item_q;

  logic [7:0]  terminator_char, field_separator_char, pair_separator_char;
  logic [31:0] timeout_ticks;
  logic [5:0]  name_limit;
  logic [7:0]  message_limit;

  logic                  reading, reading_next;
  logic                  in_name_part, in_name_part_next;
  logic                  in_key_part, in_key_part_next;
  logic [3:0]            param_count, param_count_next;
  logic [7:0]            raw_length, raw_length_next;
  logic [7:0]            name_part_length, name_part_length_next;
  logic [NAME_CNT_W-1:0] name_stored_count, name_stored_count_next;
  logic [5:0]            key_length, key_length_next;
  logic [5:0]            value_length, value_length_next;
  logic [31:0]           silence_ticks, silence_ticks_next;
  logic                  timeout_flag, timeout_flag_next;

  result_t pend, pend_next;
  logic    has_item, is_term;
  logic [5:0] len_calc, name_len, name_idx;

  logic                   ram_we, ram_re;
  logic [NAME_ADDR_W-1:0] ram_raddr;
  logic [7:0]             ram_rdata;

  logic    item_acc, out_free, load_result;
  result_t result_next;

  assign item_acc   = item_valid && !item_stall;
  assign item_stall = (state != ST_IDLE);
  assign cfg_ready  = (state == ST_IDLE);
  assign out_free   = !result_valid || !result_stall;

  clkvp_ram #(
    .WIDTH(8),
    .DEPTH(NAME_STORE_DEPTH)
  ) u_name_store (
    .clk   (clk),
    .we    (ram_we && (state == ST_EXEC)),
    .waddr (name_stored_count_next[NAME_ADDR_W-1:0] - NAME_ADDR_W'(1)),
    .wdata (item_q.byte_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic                  timeout_hit;
    logic [7:0]            c;
    logic [7:0]            raw_cur, npl_cur;
    logic [NAME_CNT_W-1:0] stored_cur;
    logic [3:0]            pc_cur;
    logic                  in_name_cur;
    logic [5:0]            lim, len;

    c           = item_q.byte_in;
    timeout_hit = (silence_ticks == '1) ? (timeout_ticks != '1)
                                         : (silence_ticks >= timeout_ticks);

    reading_next           = reading;
    in_name_part_next      = in_name_part;
    in_key_part_next       = in_key_part;
    param_count_next       = param_count;
    raw_length_next        = raw_length;
    name_part_length_next  = name_part_length;
    name_stored_count_next = name_stored_count;
    key_length_next        = key_length;
    value_length_next      = value_length;
    silence_ticks_next     = silence_ticks;
    timeout_flag_next      = timeout_flag;
    pend_next              = '0;
    has_item               = 1'b0;
    is_term                = 1'b0;
    ram_we                 = 1'b0;
    raw_cur                = raw_length;
    npl_cur                = name_part_length;
    stored_cur             = name_stored_count;
    pc_cur                 = param_count;
    in_name_cur            = in_name_part;

    lim = (name_limit == 6'd0) ? 6'd0 : name_limit - 6'd1;
    len = 6'(name_stored_count);
    if (len > lim) begin
      len = lim;
    end
    if (len > 6'(NAME_EMIT_CAP)) begin
      len = 6'(NAME_EMIT_CAP);
    end
    len_calc = len;

    if (item_q.command) begin
      if (silence_ticks != '1) begin
        silence_ticks_next = silence_ticks + 32'd1;
      end
      if (reading && timeout_hit) begin
        timeout_flag_next    = 1'b1;
        reading_next         = 1'b0;
        has_item             = 1'b1;
        pend_next.kind       = KIND_ERROR;
        pend_next.error_code = ERR_TIMEOUT;
        pend_next.timed_out  = 1'b1;
        pend_next.last       = 1'b1;
      end
    end else begin
      silence_ticks_next = '0;
      if (!reading) begin
        reading_next      = 1'b1;
        timeout_flag_next = 1'b0;
        in_name_cur       = 1'b1;
        raw_cur           = '0;
        npl_cur           = '0;
        stored_cur        = '0;
        pc_cur            = '0;
      end
      in_name_part_next      = in_name_cur;
      raw_length_next        = raw_cur;
      name_part_length_next  = npl_cur;
      name_stored_count_next = stored_cur;
      param_count_next       = pc_cur;
      pend_next.timed_out    = timeout_flag_next;
      pend_next.last         = 1'b1;
      pend_next.param_index  = 3'(pc_cur - 4'd1);

      if (raw_cur >= message_limit) begin
        reading_next         = 1'b0;
        has_item             = 1'b1;
        pend_next.kind       = KIND_ERROR;
        pend_next.error_code = ERR_RAW_FULL;
        pend_next.param_index = '0;
      end else begin
        raw_length_next = raw_cur + 8'd1;
        if (c == terminator_char) begin
          reading_next = 1'b0;
          is_term      = 1'b1;
          if (!reading) begin
            len_calc = '0;
          end
        end else if (c == field_separator_char) begin
          if (pc_cur < 4'(MAX_PARAMS)) begin
            param_count_next  = pc_cur + 4'd1;
            key_length_next   = '0;
            value_length_next = '0;
          end
          in_name_part_next = 1'b0;
          in_key_part_next  = 1'b1;
        end else if (c == pair_separator_char) begin
          in_key_part_next = 1'b0;
        end else if (in_name_cur) begin
          if (npl_cur >= message_limit) begin
            reading_next          = 1'b0;
            has_item              = 1'b1;
            pend_next.kind        = KIND_ERROR;
            pend_next.error_code  = ERR_NAME_FULL;
            pend_next.param_index = '0;
          end else begin
            name_part_length_next = npl_cur + 8'd1;
            if (!(stored_cur == '0 && is_ws(c)) &&
                stored_cur < NAME_CNT_W'(NAME_STORE_DEPTH)) begin
              ram_we                 = 1'b1;
              name_stored_count_next = stored_cur + NAME_CNT_W'(1);
            end
          end
        end else if (pc_cur != 4'd0) begin
          has_item = 1'b1;
          if (in_key_part) begin
            if (key_length >= 6'(KEY_LIMIT)) begin
              reading_next          = 1'b0;
              pend_next.kind        = KIND_ERROR;
              pend_next.error_code  = ERR_KEY_LONG;
              pend_next.param_index = '0;
            end else begin
              pend_next.kind     = KIND_KEY;
              pend_next.position = key_length;
              pend_next.char_out = c;
              key_length_next    = key_length + 6'd1;
            end
          end else begin
            if (value_length >= 6'(VALUE_LIMIT)) begin
              reading_next          = 1'b0;
              pend_next.kind        = KIND_ERROR;
              pend_next.error_code  = ERR_VALUE_LONG;
              pend_next.param_index = '0;
            end else begin
              pend_next.kind     = KIND_VALUE;
              pend_next.position = value_length;
              pend_next.char_out = c;
              value_length_next  = value_length + 6'd1;
            end
          end
        end
      end
    end
    if (!has_item) begin
      pend_next = '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_acc) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        priority if (has_item) begin
          state_next = ST_SEND;
        end else if (is_term) begin
          state_next = (len_calc == 6'd0) ? ST_END : ST_TRIM_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SEND: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_TRIM_RD: begin
        state_next = ST_TRIM_CHK;
      end
      ST_TRIM_CHK: begin
        priority if (is_ws(ram_rdata)) begin
          state_next = (name_len == 6'd1) ? ST_END : ST_TRIM_RD;
        end else begin
          state_next = ST_NAME_RD;
        end
      end
      ST_NAME_RD: begin
        state_next = ST_NAME_PUT;
      end
      ST_NAME_PUT: begin
        if (out_free) begin
          state_next = (name_idx + 6'd1 == name_len) ? ST_END : ST_NAME_RD;
        end
      end
      ST_END: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_re      = 1'b0;
    ram_raddr   = name_idx[NAME_ADDR_W-1:0];
    load_result = 1'b0;
    result_next = '0;
    unique case (state)
      ST_SEND: begin
        load_result = out_free;
        result_next = pend;
      end
      ST_TRIM_RD: begin
        ram_re    = 1'b1;
        ram_raddr = NAME_ADDR_W'(name_len - 6'd1);
      end
      ST_NAME_RD: begin
        ram_re = 1'b1;
      end
      ST_NAME_PUT: begin
        load_result          = out_free;
        result_next.kind     = KIND_NAME;
        result_next.position = name_idx;
        result_next.char_out = ram_rdata;
        result_next.timed_out = timeout_flag;
      end
      ST_END: begin
        load_result             = out_free;
        result_next.kind        = KIND_END;
        result_next.param_total = param_count;
        result_next.timed_out   = timeout_flag;
        result_next.last        = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      terminator_char      <= 8'd59;
      field_separator_char <= 8'd58;
      pair_separator_char  <= 8'd61;
      timeout_ticks        <= 32'd1000;
      name_limit           <= 6'd16;
      message_limit        <= 8'd64;
      reading              <= 1'b0;
      in_name_part         <= 1'b0;
      in_key_part          <= 1'b0;
      param_count          <= '0;
      raw_length           <= '0;
      name_part_length     <= '0;
      name_stored_count    <= '0;
      key_length           <= '0;
      value_length         <= '0;
      silence_ticks        <= '0;
      timeout_flag         <= 1'b0;
      result_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TERMINATOR:    terminator_char      <= cfg_data[7:0];
          REG_FIELD_SEP:     field_separator_char <= cfg_data[7:0];
          REG_PAIR_SEP:      pair_separator_char  <= cfg_data[7:0];
          REG_TIMEOUT:       timeout_ticks        <= cfg_data;
          REG_NAME_LIMIT:    name_limit           <= cfg_data[5:0];
          REG_MESSAGE_LIMIT: message_limit        <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (state == ST_EXEC) begin
        reading           <= reading_next;
        in_name_part      <= in_name_part_next;
        in_key_part       <= in_key_part_next;
        param_count       <= param_count_next;
        raw_length        <= raw_length_next;
        name_part_length  <= name_part_length_next;
        name_stored_count <= name_stored_count_next;
        key_length        <= key_length_next;
        value_length      <= value_length_next;
        silence_ticks     <= silence_ticks_next;
        timeout_flag      <= timeout_flag_next;
      end
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      item_q <= item;
    end
    if (state == ST_EXEC) begin
      pend     <= pend_next;
      name_len <= len_calc;
      name_idx <= '0;
    end
    if (state == ST_TRIM_CHK && is_ws(ram_rdata)) begin
      name_len <= name_len - 6'd1;
    end
    if (state == ST_NAME_PUT && out_free) begin
      name_idx <= name_idx + 6'd1;
    end
    if (load_result) begin
      result <= result_next;
    end
  end

  `ASSERT_NEXT(a_accept_exec, clk, rst, item_acc, state == ST_EXEC)
  `ASSERT_IMPLIES(a_name_in_range, clk, rst, state == ST_NAME_PUT,
                  name_idx < name_len && name_len <= 6'(NAME_EMIT_CAP))
  `ASSERT_IMPLIES(a_error_last, clk, rst,
                  result_valid && result.kind == KIND_ERROR, result.last)
  `ASSERT_IMPLIES(a_name_not_last, clk, rst,
                  result_valid && result.kind == KIND_NAME, !result.last)

endmodule

// ----- verif/parser_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts the parser's output transfers and compares them with the block.
module parser_checker
  import clkvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  item_t       item,
  input  logic        result_valid,
  input  logic        result_stall,
  input  result_t     result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  result_t     parse_events_q[$];
  int          errors = 0;

  logic [7:0]  term_char;
  logic [7:0]  field_sep;
  logic [7:0]  pair_sep;
  logic [31:0] timeout_limit;
  logic [5:0]  name_limit;
  logic [7:0]  msg_limit;

  logic        reading;
  logic        in_name;
  logic        in_key;
  logic        timeout_flag;
  logic [3:0]  params;
  logic [7:0]  raw_len;
  logic [7:0]  name_part_len;
  logic [5:0]  name_cnt;
  logic [5:0]  key_len;
  logic [5:0]  value_len;
  logic [31:0] silence;
  logic [7:0]  name_buf [NAME_STORE_DEPTH];

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic result_t base_event(input kind_t k);
    result_t r;
    r = '0;
    r.kind = k;
    r.timed_out = timeout_flag;
    return r;
  endfunction

  task automatic abort_message(input err_t code);
    result_t r;
    reading = 1'b0;
    r = base_event(KIND_ERROR);
    r.error_code = code;
    r.last = 1'b1;
    parse_events_q.push_back(r);
  endtask

  task automatic reset_parser();
    term_char = 8'h3B;
    field_sep = 8'h3A;
    pair_sep = 8'h3D;
    timeout_limit = 32'd1000;
    name_limit = 6'd16;
    msg_limit = 8'd64;
    reading = 1'b0;
    in_name = 1'b0;
    in_key = 1'b0;
    timeout_flag = 1'b0;
    params = '0;
    raw_len = '0;
    name_part_len = '0;
    name_cnt = '0;
    key_len = '0;
    value_len = '0;
    silence = '0;
    parse_events_q.delete();
  endtask

  task automatic write_setting(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      REG_TERMINATOR:    term_char = data[7:0];
      REG_FIELD_SEP:     field_sep = data[7:0];
      REG_PAIR_SEP:      pair_sep = data[7:0];
      REG_TIMEOUT:       timeout_limit = data;
      REG_NAME_LIMIT:    name_limit = data[5:0];
      REG_MESSAGE_LIMIT: msg_limit = data[7:0];
      default: ;
    endcase
  endtask

  task automatic parse_input(input item_t it);
    logic [7:0] c;
    int         n;
    int         lim;
    int         i;
    result_t    r;
    c = it.byte_in;
    if (it.command) begin
      if (silence != '1) silence++;
      if (reading && silence > timeout_limit) begin
        timeout_flag = 1'b1;
        abort_message(ERR_TIMEOUT);
      end
      return;
    end
    silence = '0;
    if (!reading) begin
      reading = 1'b1;
      timeout_flag = 1'b0;
      in_name = 1'b1;
      raw_len = '0;
      name_part_len = '0;
      name_cnt = '0;
      params = '0;
    end
    if (raw_len >= msg_limit) begin
      abort_message(ERR_RAW_FULL);
      return;
    end
    raw_len++;
    if (c == term_char) begin
      reading = 1'b0;
      n = int'(name_cnt);
      lim = (name_limit == 0) ? 0 : int'(name_limit) - 1;
      if (n > lim) n = lim;
      if (n > NAME_EMIT_CAP) n = NAME_EMIT_CAP;
      while (n > 0 && is_blank(name_buf[NAME_ADDR_W'(n - 1)])) n--;
      for (i = 0; i < n; i++) begin
        r = base_event(KIND_NAME);
        r.position = i[5:0];
        r.char_out = name_buf[NAME_ADDR_W'(i)];
        parse_events_q.push_back(r);
      end
      r = base_event(KIND_END);
      r.param_total = params;
      r.last = 1'b1;
      parse_events_q.push_back(r);
      return;
    end
    if (c == field_sep) begin
      if (params < MAX_PARAMS) begin
        params++;
        key_len = '0;
        value_len = '0;
      end
      in_name = 1'b0;
      in_key = 1'b1;
      return;
    end
    if (c == pair_sep) begin
      in_key = 1'b0;
      return;
    end
    if (in_name) begin
      if (name_part_len >= msg_limit) begin
        abort_message(ERR_NAME_FULL);
        return;
      end
      name_part_len++;
      if (!(name_cnt == 0 && is_blank(c)) && name_cnt < NAME_STORE_DEPTH) begin
        name_buf[name_cnt[NAME_ADDR_W-1:0]] = c;
        name_cnt++;
      end
      return;
    end
    if (params == 0) return;
    if (in_key) begin
      if (key_len >= KEY_LIMIT) begin
        abort_message(ERR_KEY_LONG);
        return;
      end
      r = base_event(KIND_KEY);
      r.position = key_len;
      key_len++;
    end else begin
      if (value_len >= VALUE_LIMIT) begin
        abort_message(ERR_VALUE_LONG);
        return;
      end
      r = base_event(KIND_VALUE);
      r.position = value_len;
      value_len++;
    end
    r.param_index = 3'(params - 1);
    r.char_out = c;
    r.last = 1'b1;
    parse_events_q.push_back(r);
  endtask

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (parse_events_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got %h", $time, got);
      return;
    end
    want = parse_events_q.pop_front();
    check_field("kind", 8'(want.kind), 8'(got.kind));
    check_field("param_index", 8'(want.param_index), 8'(got.param_index));
    check_field("position", 8'(want.position), 8'(got.position));
    check_field("char_out", want.char_out, got.char_out);
    check_field("param_total", 8'(want.param_total), 8'(got.param_total));
    check_field("error_code", 8'(want.error_code), 8'(got.error_code));
    check_field("timed_out", 8'(want.timed_out), 8'(got.timed_out));
    check_field("last", 8'(want.last), 8'(got.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_parser();
    end else begin
      if (result_valid && !result_stall) check_result(result);
      if (cfg_valid && cfg_ready) write_setting(cfg_index, cfg_data);
      if (item_valid && !item_stall) parse_input(item);
    end
    pending <= parse_events_q.size();
    fail_count <= errors;
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench top that drives the parser's channels and reports the verdict.
module tb;
  import clkvp_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum {SHAPE_LONG_NAME, SHAPE_MANY_PARAMS, SHAPE_LONG_KEY, SHAPE_LONG_VALUE,
                SHAPE_PLAIN} msg_shape_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int          fail_count;
  int          pending;
  int          burst_left = 0;
  int          items_sent = 0;
  int          budget_end = 0;
  int          idle_cycles = 0;
  int          stall_phase = 0;
  stall_mode_t stall_mode = STALL_NONE;
  logic [7:0]  cur_term = 8'h3B;
  logic [7:0]  cur_fsep = 8'h3A;
  logic [7:0]  cur_psep = 8'h3D;
  logic [7:0]  blanks [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

  command_line_key_value_parser dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  parser_checker chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    stall_phase++;
    if (stall_phase % 80 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  result_stall <= 1'b0;
      STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
      default:     result_stall <= stall_phase[2];
    endcase
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    item_t it;
    it.command = 1'b0;
    it.byte_in = b;
    send_item(it);
  endtask

  task automatic send_tick();
    item_t it;
    it.command = 1'b1;
    it.byte_in = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  // Occasional ticks land inside a message so that timeouts hit every part of it.
  // Once the traffic budget is used up the rest of the message is left unsent.
  task automatic send_char(input logic [7:0] b);
    if (items_sent >= budget_end) return;
    if ($urandom_range(0, 11) == 0) repeat ($urandom_range(1, 4)) send_tick();
    send_byte(b);
  endtask

  function automatic logic [7:0] content_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == cur_term || c == cur_fsep || c == cur_psep);
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    return blanks[$urandom_range(0, 3)];
  endfunction

  task automatic send_message();
    msg_shape_t shape;
    int         n_name;
    int         n_params;
    int         n_key;
    int         n_val;
    int         p;
    shape = ($urandom_range(0, 9) > 3) ? SHAPE_PLAIN : msg_shape_t'($urandom_range(0, 3));
    repeat ($urandom_range(0, 2)) send_char(blank_char());
    n_name = (shape == SHAPE_LONG_NAME) ? $urandom_range(30, 36) : $urandom_range(0, 6);
    repeat (n_name) send_char(($urandom_range(0, 4) == 0) ? blank_char() : content_char());
    repeat ($urandom_range(0, 2)) send_char(blank_char());
    n_params = (shape == SHAPE_MANY_PARAMS) ? $urandom_range(9, 10) : $urandom_range(0, 3);
    for (p = 0; p < n_params; p++) begin
      send_char(cur_fsep);
      n_key = (shape == SHAPE_LONG_KEY && p == 0) ? 17 : $urandom_range(0, 3);
      repeat (n_key) send_char(content_char());
      if ($urandom_range(0, 1) == 1) begin
        send_char(cur_psep);
        n_val = (shape == SHAPE_LONG_VALUE && p == 0) ? 33 : $urandom_range(0, 4);
        repeat (n_val) send_char(content_char());
      end
    end
    if ($urandom_range(0, 9) != 0) send_char(cur_term);
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(1, 6)) send_tick();
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_traffic(input int count);
    budget_end = items_sent + count;
    while (items_sent < budget_end) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_message();
    end
  endtask

  // Stops driving items and waits until nothing is expected any more.
  task automatic drain();
    int quiet;
    quiet = 0;
    item_valid <= 1'b0;
    burst_left = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk);
      if (pending != 0) quiet = 0;
      else quiet++;
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] term, input logic [7:0] fsep,
                           input logic [7:0] psep, input logic [31:0] ticks,
                           input logic [5:0] name_lim, input logic [7:0] msg_lim);
    drain();
    write_reg(REG_TERMINATOR, 32'(term));
    write_reg(REG_FIELD_SEP, 32'(fsep));
    write_reg(REG_PAIR_SEP, 32'(psep));
    write_reg(REG_TIMEOUT, ticks);
    write_reg(REG_NAME_LIMIT, 32'(name_lim));
    write_reg(REG_MESSAGE_LIMIT, 32'(msg_lim));
    cfg_valid <= 1'b0;
    cur_term = term;
    cur_fsep = fsep;
    cur_psep = psep;
  endtask

  task automatic configure_random();
    logic [7:0] t;
    logic [7:0] f;
    logic [7:0] p;
    t = 8'($urandom_range(33, 126));
    do f = 8'($urandom_range(33, 126)); while (f == t);
    do p = 8'($urandom_range(33, 126)); while (p == t || p == f);
    configure(t, f, p, $urandom_range(2, 40), 6'($urandom_range(0, 63)),
              8'($urandom_range(20, 255)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: idle tick, blank trimming, key and value, byte extremes.
    send_tick();
    send_byte(CH_SPACE);
    send_byte(CH_TAB);
    send_byte("N");
    send_byte("m");
    send_byte(CH_SPACE);
    send_byte(CH_CR);
    send_byte(":");
    send_byte("k");
    send_byte("=");
    send_byte("v");
    send_byte(";");
    send_byte(8'hFF);
    send_byte(":");
    send_byte(8'h00);
    send_byte("=");
    send_byte(8'h7F);
    send_byte(";");
    run_traffic(36);

    // Zero timeout and zero name limit: a tick inside a message aborts it.
    configure(8'h00, 8'hFF, 8'h80, 32'h0000_0000, 6'd0, 8'd255);
    send_byte("a");
    send_byte(8'hFF);
    send_byte("b");
    send_byte(8'h80);
    send_byte("c");
    send_tick();
    send_byte("x");
    send_byte(8'h00);
    run_traffic(14);

    // Zero message limit makes every byte overflow.
    configure(8'hFF, 8'h00, 8'h7F, 32'hFFFF_FFFF, 6'd63, 8'd0);
    run_traffic(8);

    configure(";", ":", "=", 32'd5, 6'd33, 8'd1);
    run_traffic(10);

    configure(".", ",", "=", 32'd3, 6'd1, 8'd200);
    run_traffic(12);

    configure_random();
    run_traffic(12);
    configure_random();
    run_traffic(12);

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/clkvp_pkg.sv
src/clkvp_ram.sv
src/command_line_key_value_parser.sv
verif/parser_checker.sv
verif/tb.sv
